// ===== rtl/core/mouse_report_encoder_macros.svh =====
// assertion macros for the mouse report encoder
// used by mre_back under rtl/core, expects clk and rst in scope
`ifndef MOUSE_REPORT_ENCODER_MACROS_SVH
`define MOUSE_REPORT_ENCODER_MACROS_SVH
`ifndef ASSERT_OFF
`define MRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRE_ASSERT(lbl, prop, msg)
`define MRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/mre_pkg.sv =====
// shared types, codes and constants of the mouse report encoder
// no dependencies
`default_nettype none
package mre_pkg;
  localparam int COORD_BITS   = 13;
  localparam int NUM_BITS     = 16;
  localparam int LEGACY_LIMIT = 223;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MOVE    = 2'd2;

  localparam logic [2:0] BTN_NONE       = 3'd3;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

  localparam logic [2:0] LVL_PRESS     = 3'd1;
  localparam logic [2:0] LVL_NORMAL    = 3'd2;
  localparam logic [2:0] LVL_BUTTON    = 3'd3;
  localparam logic [2:0] LVL_ANY       = 3'd4;
  localparam logic [2:0] LVL_HIGHLIGHT = 3'd5;

  localparam logic [2:0] FMT_LEGACY = 3'd0;
  localparam logic [2:0] FMT_SGR    = 3'd2;
  localparam logic [2:0] FMT_DEC    = 3'd3;
  localparam logic [2:0] FMT_PIX    = 3'd4;

  localparam logic [1:0] WHEEL_NORMAL = 2'd1;
  localparam logic [1:0] WHEEL_APP    = 2'd2;

  localparam logic [1:0] REG_TRACKING = 2'd0;
  localparam logic [1:0] REG_FORMAT   = 2'd1;
  localparam logic [1:0] REG_WHEEL    = 2'd2;
  localparam logic [1:0] REG_PASSIVE  = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_UM    = 8'h4d;
  localparam logic [7:0] CH_LM    = 8'h6d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CODE_WHEEL  = 8'h3c;
  localparam logic [7:0] CODE_DRAG   = 8'h20;
  localparam logic [7:0] BYTE_OFFSET = 8'h20;

  typedef enum logic [1:0] {KIND_NONE, KIND_FIXED, KIND_NUM} kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [5:0][7:0]            hb;
    logic [2:0]                 hlast;
    logic [7:0]                 code;
    logic [NUM_BITS-1:0]        nx;
    logic [NUM_BITS-1:0]        ny;
    logic [7:0]                 fin;
    logic                       ui_field;
    logic                       ui;
    logic                       acc;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       acc;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [NUM_BITS:0] pow10(input logic [2:0] pos);
    logic [NUM_BITS:0] p;
    case (pos)
      3'd1: p = (NUM_BITS+1)'(10);
      3'd2: p = (NUM_BITS+1)'(100);
      3'd3: p = (NUM_BITS+1)'(1000);
      3'd4: p = (NUM_BITS+1)'(10000);
      default: p = (NUM_BITS+1)'(1);
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mre_front.sv =====
// front part: config registers, position and button state, event classification
// depends on mre_pkg
`default_nettype none
module mre_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic [1:0]                           op,
  input  logic [2:0]                           button,
  input  logic [2:0]                           modifier_bits,
  input  logic signed [mre_pkg::COORD_BITS-1:0] cell_line,
  input  logic signed [mre_pkg::COORD_BITS-1:0] cell_column,
  input  logic [15:0]                          pixel_x,
  input  logic [15:0]                          pixel_y,
  input  logic                                 ui_handled,
  input  logic                                 cfg_valid,
  input  logic [1:0]                           cfg_index,
  input  logic [2:0]                           cfg_data,
  input  mre_pkg::qstat_t                      qstat,
  output logic                                 q_push,
  output mre_pkg::job_t                        q_job
);
  localparam int CB = mre_pkg::COORD_BITS;
  localparam int NB = mre_pkg::NUM_BITS;

  logic [2:0]    tracking_level;
  logic [2:0]    report_format;
  logic [1:0]    wheel_mode;
  logic          passive_tracking;
  logic [CB-1:0] last_line;
  logic [CB-1:0] last_column;
  logic [3:0]    held_buttons;

  logic [CB-1:0] lraw, craw;
  logic          accept, active, negpos, sgrlike, same, wheel_key, do_gen;
  logic          gen_acc, report, tx, legacy_ok, upd_pos;
  logic [2:0]    drag_btn, gbtn;
  logic [7:0]    code;
  logic [NB-1:0] col1, line1;
  mre_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_level   <= '0;
      report_format    <= '0;
      wheel_mode       <= '0;
      passive_tracking <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mre_pkg::REG_TRACKING: tracking_level   <= cfg_data;
        mre_pkg::REG_FORMAT:   report_format    <= cfg_data;
        mre_pkg::REG_WHEEL:    wheel_mode       <= cfg_data[1:0];
        mre_pkg::REG_PASSIVE:  passive_tracking <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lraw    = cell_line;
  assign craw    = cell_column;
  assign accept  = push & ~qstat.full;
  assign active  = tracking_level inside {[mre_pkg::LVL_PRESS:mre_pkg::LVL_HIGHLIGHT]};
  assign gen_acc = tracking_level inside {[mre_pkg::LVL_PRESS:mre_pkg::LVL_ANY]};
  assign negpos  = lraw[CB-1] | craw[CB-1];
  assign sgrlike = report_format inside {mre_pkg::FMT_SGR, mre_pkg::FMT_PIX};
  assign same    = (lraw == last_line) && (craw == last_column);
  assign wheel_key = (wheel_mode inside {mre_pkg::WHEEL_NORMAL, mre_pkg::WHEEL_APP}) &&
                     !passive_tracking &&
                     (button inside {mre_pkg::BTN_WHEEL_UP, mre_pkg::BTN_WHEEL_DOWN});
  assign upd_pos = (op == mre_pkg::OP_PRESS) || (op == mre_pkg::OP_RELEASE) ||
                   ((op == mre_pkg::OP_MOVE) && (!same || report_format == mre_pkg::FMT_PIX));
  assign col1      = NB'(craw) + NB'(1);
  assign line1     = NB'(lraw) + NB'(1);
  assign legacy_ok = (lraw < CB'(mre_pkg::LEGACY_LIMIT)) && (craw < CB'(mre_pkg::LEGACY_LIMIT));

  always_comb begin
    drag_btn = mre_pkg::BTN_NONE;
    for (int i = 3; i >= 0; i--) begin
      if (held_buttons[i]) drag_btn = 3'(i);
    end
  end

  always_comb begin
    do_gen = 1'b0;
    gbtn   = button;
    case (op)
      mre_pkg::OP_PRESS:   do_gen = active & ~wheel_key;
      mre_pkg::OP_RELEASE: do_gen = active;
      mre_pkg::OP_MOVE: begin
        gbtn   = drag_btn;
        do_gen = upd_pos && active &&
                 ((tracking_level == mre_pkg::LVL_BUTTON && held_buttons != 4'd0) ||
                  tracking_level == mre_pkg::LVL_ANY);
      end
      default: do_gen = 1'b0;
    endcase
  end

  always_comb begin
    code = gbtn[2] ? 8'(gbtn) + mre_pkg::CODE_WHEEL : 8'(gbtn);
    if (!sgrlike && op == mre_pkg::OP_RELEASE) code = 8'(mre_pkg::BTN_NONE);
    if (op == mre_pkg::OP_MOVE) code = code + mre_pkg::CODE_DRAG;
    code = code | {3'b000, modifier_bits, 2'b00};
  end

  always_comb begin
    case (tracking_level)
      mre_pkg::LVL_PRESS:  report = (op == mre_pkg::OP_PRESS);
      mre_pkg::LVL_NORMAL: report = (op == mre_pkg::OP_PRESS) || (op == mre_pkg::OP_RELEASE);
      mre_pkg::LVL_BUTTON: report = 1'b1;
      mre_pkg::LVL_ANY:    report = 1'b1;
      default:             report = 1'b0;
    endcase
  end

  assign tx = do_gen & report & ~negpos;

  always_comb begin
    job          = '0;
    job.kind     = mre_pkg::KIND_NONE;
    job.code     = code;
    job.ui       = ui_handled;
    job.ui_field = passive_tracking;
    job.fin      = (op == mre_pkg::OP_RELEASE) ? mre_pkg::CH_LM : mre_pkg::CH_UM;
    job.nx       = col1;
    job.ny       = line1;
    job.acc      = do_gen & gen_acc;
    job.hb[0]    = mre_pkg::CH_ESC;
    job.hb[1]    = mre_pkg::CH_LBRK;
    job.hb[2]    = mre_pkg::CH_LT;
    job.hlast    = 3'd2;
    if (op == mre_pkg::OP_PRESS && active && wheel_key) begin
      job.kind  = mre_pkg::KIND_FIXED;
      job.acc   = 1'b1;
      job.hb[1] = (wheel_mode == mre_pkg::WHEEL_NORMAL) ? mre_pkg::CH_LBRK : mre_pkg::CH_O;
      job.hb[2] = (button == mre_pkg::BTN_WHEEL_UP) ? mre_pkg::CH_A : mre_pkg::CH_B;
    end else if (tx) begin
      case (report_format)
        mre_pkg::FMT_LEGACY: begin
          if (legacy_ok) begin
            job.kind  = mre_pkg::KIND_FIXED;
            job.hb[2] = mre_pkg::CH_UM;
            job.hb[3] = mre_pkg::BYTE_OFFSET + code;
            job.hb[4] = mre_pkg::BYTE_OFFSET + col1[7:0];
            job.hb[5] = mre_pkg::BYTE_OFFSET + line1[7:0];
            job.hlast = 3'd5;
          end
        end
        mre_pkg::FMT_SGR: job.kind = mre_pkg::KIND_NUM;
        mre_pkg::FMT_DEC: begin
          if (op == mre_pkg::OP_PRESS) begin
            job.kind     = mre_pkg::KIND_NUM;
            job.hlast    = 3'd1;
            job.ui_field = 1'b0;
          end
        end
        mre_pkg::FMT_PIX: begin
          job.kind = mre_pkg::KIND_NUM;
          job.nx   = pixel_x;
          job.ny   = pixel_y;
        end
        default: job.kind = mre_pkg::KIND_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_line    <= '0;
      last_column  <= '0;
      held_buttons <= '0;
    end else if (accept) begin
      if (upd_pos) begin
        last_line   <= lraw;
        last_column <= craw;
      end
      if (op == mre_pkg::OP_RELEASE && !button[2]) held_buttons[button[1:0]] <= 1'b0;
      if (op == mre_pkg::OP_PRESS && active && !wheel_key && !button[2])
        held_buttons[button[1:0]] <= 1'b1;
    end
  end

  assign q_push = accept;
  assign q_job  = job;
endmodule
`default_nettype wire

// ===== rtl/core/mre_job_queue.sv =====
// two-entry queue of classified events between front and back
// depends on mre_pkg
`default_nettype none
module mre_job_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  mre_pkg::job_t   wdata,
  input  logic            rd,
  output mre_pkg::job_t   rdata,
  output mre_pkg::qstat_t qstat
);
  mre_pkg::job_t mem [2];
  logic          wptr, rptr;
  logic [1:0]    cnt;
  logic          do_wr, do_rd;

  assign qstat.full  = (cnt == 2'd2);
  assign qstat.empty = (cnt == 2'd0);
  assign do_wr = wr & ~qstat.full;
  assign do_rd = rd & ~qstat.empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mre_back.sv =====
// back part: one event to beats, decimal digits one per cycle unless stalled
// depends on mre_pkg and mouse_report_encoder_macros.svh
`default_nettype none
`include "mouse_report_encoder_macros.svh"
module mre_back (
  input  logic            clk,
  input  logic            rst,
  input  mre_pkg::qstat_t qstat,
  input  mre_pkg::job_t   q_job,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output mre_pkg::result_t res
);
  localparam int NB = mre_pkg::NUM_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NONE = 6'b000010,
    S_HEAD = 6'b000100,
    S_NUM  = 6'b001000,
    S_SEP  = 6'b010000,
    S_TAIL = 6'b100000
  } state_t;

  state_t           state, state_next;
  mre_pkg::job_t    cur, cur_next;
  logic [2:0]       hidx, hidx_next, pos, pos_next;
  logic [1:0]       nsel, nsel_next, tidx, tidx_next;
  logic [NB-1:0]    rem, rem_next;
  logic             started, started_next;

  logic [NB:0]      p, sub;
  logic [3:0]       digit;
  logic             show;

  mre_pkg::result_t omem [2];
  logic             owp, orp;
  logic [1:0]       ocnt;
  logic             go, wr, rd;
  mre_pkg::result_t wdata;

  assign go = (ocnt != 2'd2);

  always_comb begin
    p     = mre_pkg::pow10(pos);
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem} >= (NB+1)'(k) * p) digit = 4'(k);
    end
    sub  = (NB+1)'(digit) * p;
    show = (digit != 4'd0) || started || (pos == 3'd0);
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    hidx_next    = hidx;
    pos_next     = pos;
    nsel_next    = nsel;
    tidx_next    = tidx;
    rem_next     = rem;
    started_next = started;
    q_pop        = 1'b0;
    wr           = 1'b0;
    wdata        = '0;
    case (state)
      S_IDLE: begin
        if (!qstat.empty) begin
          q_pop      = 1'b1;
          cur_next   = q_job;
          hidx_next  = 3'd0;
          state_next = (q_job.kind == mre_pkg::KIND_NONE) ? S_NONE : S_HEAD;
        end
      end
      S_NONE: begin
        if (go) begin
          wr         = 1'b1;
          wdata.last = 1'b1;
          wdata.acc  = cur.acc;
          state_next = S_IDLE;
        end
      end
      S_HEAD: begin
        if (go) begin
          wr          = 1'b1;
          wdata.data  = cur.hb[hidx];
          wdata.valid = 1'b1;
          hidx_next   = hidx + 3'd1;
          if (hidx == cur.hlast) begin
            if (cur.kind == mre_pkg::KIND_FIXED) begin
              wdata.last = 1'b1;
              wdata.acc  = cur.acc;
              state_next = S_IDLE;
            end else begin
              state_next   = S_NUM;
              nsel_next    = 2'd0;
              rem_next     = NB'(cur.code);
              pos_next     = 3'd2;
              started_next = 1'b0;
            end
          end
        end
      end
      S_NUM: begin
        if (go) begin
          wr           = show;
          wdata.data   = mre_pkg::CH_ZERO + 8'(digit);
          wdata.valid  = 1'b1;
          started_next = started | show;
          rem_next     = rem - sub[NB-1:0];
          pos_next     = pos - 3'd1;
          if (pos == 3'd0) begin
            started_next = 1'b0;
            if (nsel == 2'd2) begin
              state_next = S_TAIL;
              tidx_next  = cur.ui_field ? 2'd0 : 2'd2;
            end else begin
              state_next = S_SEP;
            end
          end
        end
      end
      S_SEP: begin
        if (go) begin
          wr          = 1'b1;
          wdata.data  = mre_pkg::CH_SEMI;
          wdata.valid = 1'b1;
          nsel_next   = nsel + 2'd1;
          rem_next    = (nsel == 2'd0) ? cur.nx : cur.ny;
          pos_next    = 3'd4;
          state_next  = S_NUM;
        end
      end
      S_TAIL: begin
        if (go) begin
          wr          = 1'b1;
          wdata.valid = 1'b1;
          tidx_next   = tidx + 2'd1;
          case (tidx)
            2'd0: wdata.data = mre_pkg::CH_SEMI;
            2'd1: wdata.data = mre_pkg::CH_ZERO + 8'(cur.ui);
            default: begin
              wdata.data = cur.fin;
              wdata.last = 1'b1;
              wdata.acc  = cur.acc;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    hidx <= hidx_next;
    pos  <= pos_next;
    nsel <= nsel_next;
    tidx <= tidx_next;
    rem  <= rem_next;
  end

  // result queue
  assign rd    = pop & (ocnt != 2'd0);
  assign empty = (ocnt == 2'd0);
  assign res   = omem[orp];

  always_ff @(posedge clk) begin
    if (wr) omem[owp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (wr) owp <= ~owp;
      if (rd) orp <= ~orp;
      ocnt <= ocnt + 2'(wr) - 2'(rd);
    end
  end

  `MRE_ASSERT(a_last_ends_event, (wr && wdata.last) |=> (state == S_IDLE), "event did not end on last beat")
  `MRE_ASSERT(a_acc_only_last, (wr && !wdata.last) |-> !wdata.acc, "accepted flag on non-last beat")
  `MRE_ASSERT(a_empty_is_last, (wr && !wdata.valid) |-> wdata.last, "byteless beat not last")
  `MRE_ASSERT(a_head_in_range, (state == S_HEAD) |-> (hidx <= cur.hlast), "head index overrun")
endmodule
`default_nettype wire

// ===== rtl/core/mouse_report_encoder.sv =====
// mouse report encoder top level: front, job queue and back
// an accepted event goes into the job queue, is taken by the back part's state machine
// and its beats are written to the result queue, one beat per cycle with a bubble per
// skipped leading digit while pop keeps that queue from filling; the back part takes
// the next event from the job queue only once the previous event's last beat is written
// synchronous active-high reset clears config, held buttons, position and all queues
`default_nettype none
module mouse_report_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           op,
  input  logic [2:0]                           button,
  input  logic [2:0]                           modifier_bits,
  input  logic signed [mre_pkg::COORD_BITS-1:0] cell_line,
  input  logic signed [mre_pkg::COORD_BITS-1:0] cell_column,
  input  logic [15:0]                          pixel_x,
  input  logic [15:0]                          pixel_y,
  input  logic                                 ui_handled,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [7:0]                           out_byte,
  output logic                                 byte_valid,
  output logic                                 last,
  output logic                                 accepted,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [2:0]                           cfg_data
);
  mre_pkg::qstat_t  qstat;
  mre_pkg::job_t    push_job, head_job;
  mre_pkg::result_t res;
  logic             q_push, q_pop;

  assign cfg_ready = 1'b1;
  assign full      = qstat.full;

  mre_front u_front (
    .clk, .rst, .push, .op, .button, .modifier_bits, .cell_line, .cell_column,
    .pixel_x, .pixel_y, .ui_handled, .cfg_valid, .cfg_index, .cfg_data,
    .qstat, .q_push, .q_job(push_job)
  );

  mre_job_queue u_queue (
    .clk, .rst, .wr(q_push), .wdata(push_job), .rd(q_pop), .rdata(head_job), .qstat
  );

  mre_back u_back (
    .clk, .rst, .qstat, .q_job(head_job), .q_pop, .pop, .empty, .res
  );

  assign out_byte   = res.data;
  assign byte_valid = res.valid;
  assign last       = res.last;
  assign accepted   = res.acc;
endmodule
`default_nettype wire
